// File: rtl/ppe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types, codes and the sine magnitude table of the point pool engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_SPAWN = 3'd2;
  localparam logic [2:0] OP_FAN   = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;
  localparam logic [2:0] OP_DRAW  = 3'd5;

  localparam logic [1:0] ACT_STATUS = 2'd0;
  localparam logic [1:0] ACT_SHOW   = 2'd1;
  localparam logic [1:0] ACT_HIDE   = 2'd2;

  localparam logic [7:0] X_MIN = 8'd8;
  localparam logic [7:0] X_MAX = 8'd247;
  localparam logic [7:0] Y_MIN = 8'd24;
  localparam logic [7:0] Y_MAX = 8'd231;
  localparam logic [7:0] HIT_R = 8'd4;
  localparam logic [7:0] GRAZE_R = 8'd12;
  localparam int unsigned PHASE_STEP = 13;
  localparam logic [6:0] SPRITES = 7'd64;

  typedef struct packed {
    logic [7:0] px;
    logic [7:0] fx;
    logic [7:0] py;
    logic [7:0] fy;
    logic [7:0] vx;
    logic [7:0] vy;
    logic       grazed;
    logic       live;
  } slot_t;

  typedef enum logic [1:0] {
    HM_PASS = 2'd0,
    HM_TICK = 2'd1,
    HM_LOAD = 2'd2
  } head_mode_t;

  typedef struct packed {
    logic alive;
    logic hit;
    logic graze;
  } head_stat_t;

  function automatic logic [6:0] sine_mag(input logic [3:0] a);
    logic [6:0] m;
    case (a)
      4'd0:  m = 7'd0;
      4'd1:  m = 7'd12;
      4'd2:  m = 7'd24;
      4'd3:  m = 7'd36;
      4'd4:  m = 7'd45;
      4'd5:  m = 7'd53;
      4'd6:  m = 7'd59;
      4'd7:  m = 7'd63;
      4'd8:  m = 7'd64;
      4'd9:  m = 7'd63;
      4'd10: m = 7'd59;
      4'd11: m = 7'd53;
      4'd12: m = 7'd45;
      4'd13: m = 7'd36;
      4'd14: m = 7'd24;
      4'd15: m = 7'd12;
      default: m = 7'd0;
    endcase
    return m;
  endfunction

  // sine * speed / 64, truncated toward zero, as an 8-bit Q4.4 pattern
  function automatic logic [7:0] fan_vel(input logic [4:0] ang, input logic [6:0] spd);
    logic [13:0] prod;
    logic [7:0]  mag;
    prod = sine_mag(ang[3:0]) * spd;
    mag  = {1'b0, prod[12:6]};
    return ang[4] ? 8'(8'd0 - mag) : mag;
  endfunction

endpackage

// File: rtl/ppe_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_cell
// One pool slot of the rotating ring; takes its neighbor's slot on shift.
// ----------------------------------------------------------------------------
module ppe_cell
  import ppe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  clear,
  input  logic  shift,
  input  slot_t d,
  output slot_t q
);

  slot_t data;
  logic  live;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (clear) begin
      live <= 1'b0;
    end else if (shift) begin
      live <= d.live;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d;
    end
  end

  always_comb begin
    q      = data;
    q.live = live;
  end

endmodule

// File: rtl/ppe_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_head
// Slot processing at the ring head: motion, culling, hit and graze, spawn load.
// ----------------------------------------------------------------------------
module ppe_head
  import ppe_pkg::*;
(
  input  head_mode_t mode,
  input  slot_t      slot_in,
  input  logic [7:0] player_x,
  input  logic [7:0] player_y,
  input  logic       invulnerable,
  input  logic [7:0] load_x,
  input  logic [7:0] load_y,
  input  logic [7:0] load_vx,
  input  logic [7:0] load_vy,
  output slot_t      slot_out,
  output head_stat_t stat
);

  logic [15:0] nx, ny;
  logic [7:0]  dx, dy;

  always_comb begin
    nx = {slot_in.px, slot_in.fx} + {{4{slot_in.vx[7]}}, slot_in.vx, 4'd0};
    ny = {slot_in.py, slot_in.fy} + {{4{slot_in.vy[7]}}, slot_in.vy, 4'd0};
    dx = (nx[15:8] >= player_x) ? nx[15:8] - player_x : player_x - nx[15:8];
    dy = (ny[15:8] >= player_y) ? ny[15:8] - player_y : player_y - ny[15:8];
    slot_out = slot_in;
    stat     = '0;
    case (mode)
      HM_LOAD: begin
        slot_out = '{px: load_x, fx: 8'd0, py: load_y, fy: 8'd0,
                     vx: load_vx, vy: load_vy, grazed: 1'b0, live: 1'b1};
      end
      HM_TICK: begin
        if (slot_in.live) begin
          {slot_out.px, slot_out.fx} = nx;
          if (nx[15:8] < X_MIN || nx[15:8] > X_MAX) begin
            slot_out.live = 1'b0;
          end else begin
            {slot_out.py, slot_out.fy} = ny;
            if (ny[15:8] < Y_MIN || ny[15:8] > Y_MAX) begin
              slot_out.live = 1'b0;
            end else if (dx < HIT_R && dy < HIT_R) begin
              if (invulnerable) begin
                stat.alive = 1'b1;
              end else begin
                stat.hit      = 1'b1;
                slot_out.live = 1'b0;
              end
            end else begin
              stat.alive = 1'b1;
              if (!slot_in.grazed && dx < GRAZE_R && dy < GRAZE_R) begin
                slot_out.grazed = 1'b1;
                stat.graze      = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        slot_out = slot_in;
      end
    endcase
  end

endmodule

// File: rtl/projectile_pool_engine_unit.sv
`timescale 1ns / 1ps
// Clear, reset and unknown operations go straight to ST_DONE, which registers the status.
// Spawn: ST_SEEK rotates the ring to the cursor, then ST_SPAWN walks to a free slot.
// Fan: each placed point takes the spawn path; a refused point only passes ST_POINT.
// Tick: ST_TICK passes the whole ring once, then ST_DONE gives the status.
// Draw: ring shifts one slot per cycle, but holds a live head slot while output stalls.
// One transaction at a time. Reset clears every live flag at once; no clearing pass.
// ----------------------------------------------------------------------------
// projectile_pool_engine_unit
// Point pool on a rotating ring of slot cells with spawn, fan, tick and draw.
// ----------------------------------------------------------------------------
module projectile_pool_engine_unit
  import ppe_pkg::*;
#(
  parameter int POOL_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [7:0]  vel_x,
  input  logic [7:0]  vel_y,
  input  logic [7:0]  direction,
  input  logic [7:0]  angle_step,
  input  logic [7:0]  count,
  input  logic [7:0]  speed,
  input  logic        invulnerable,
  input  logic [7:0]  first_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  sprite_action,
  output logic [5:0]  sprite_index,
  output logic [7:0]  sprite_x,
  output logic [7:0]  sprite_y,
  output logic        last,
  output logic [6:0]  accepted,
  output logic        hit,
  output logic [6:0]  graze_count,
  output logic [6:0]  count_value,
  output logic [6:0]  peak_count,
  output logic [15:0] spawned_total,
  output logic [15:0] rejected_total
);

  localparam int IW = $clog2(POOL_SIZE);
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int XW = (CW > 7) ? CW : 7;
  localparam int STEP = PHASE_STEP % POOL_SIZE;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_POINT = 8'b00000010,
    ST_SEEK  = 8'b00000100,
    ST_SPAWN = 8'b00001000,
    ST_TICK  = 8'b00010000,
    ST_DRAW  = 8'b00100000,
    ST_HIDE  = 8'b01000000,
    ST_DONE  = 8'b10000000
  } state_t;

  state_t state;
  logic [2:0]    op_r;
  logic [7:0]    px_r, py_r, vx_r, vy_r;
  logic [4:0]    angle, step_r;
  logic [6:0]    spd_r;
  logic          invul_r, fan_r, zero_cnt;
  logic [5:0]    first_r;
  logic [CW-1:0] rem, acc, walk;
  logic [6:0]    slots, drawn, n;
  logic [IW-1:0] head, target, cursor, phase;
  logic [CW-1:0] live_count, peak_live, graze_total;
  logic          hit_flag;
  logic [15:0]   spawn_counter, reject_counter;

  slot_t         cell_q [POOL_SIZE];
  slot_t         head_out;
  head_stat_t    hstat;
  head_mode_t    hmode;
  logic [POOL_SIZE-1:0] lives;
  logic          shift, clear_all, in_acc, out_free, emit;
  logic [IW-1:0] head_inc;
  logic [IW:0]   ph_sum;
  logic [IW-1:0] ph_next;
  logic [6:0]    slots_next, room;
  logic [6:0]    drawn_next;
  logic          bad_pos, pool_full;
  logic [7:0]    load_vx, load_vy;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign clear_all = in_acc && (operation inside {OP_CLEAR, OP_RESET});
  assign emit     = out_free && ((state == ST_DRAW && cell_q[0].live) ||
                                 state == ST_HIDE || state == ST_DONE);

  assign head_inc = (head == IW'(POOL_SIZE - 1)) ? '0 : head + 1'b1;
  assign ph_sum   = {1'b0, phase} + (IW + 1)'(STEP);
  assign ph_next  = (ph_sum >= (IW + 1)'(POOL_SIZE)) ?
                    IW'(ph_sum - (IW + 1)'(POOL_SIZE)) : IW'(ph_sum);
  assign room       = SPRITES - {1'b0, first_slot[5:0]};
  assign slots_next = ({1'b0, count} > {1'b0, room}) ? room : count[6:0];
  assign drawn_next = (XW'(live_count) >= XW'(slots_next)) ? slots_next : 7'(live_count);

  assign bad_pos   = px_r < X_MIN || px_r > X_MAX || py_r < Y_MIN || py_r > Y_MAX;
  assign pool_full = (live_count == CW'(POOL_SIZE));
  assign load_vx   = fan_r ? fan_vel(angle + 5'd8, spd_r) : vx_r;
  assign load_vy   = fan_r ? fan_vel(angle, spd_r) : vy_r;

  always_comb begin
    shift = 1'b0;
    hmode = HM_PASS;
    case (state)
      ST_SEEK:  shift = (head != target);
      ST_SPAWN: begin
        shift = 1'b1;
        if (!cell_q[0].live) hmode = HM_LOAD;
      end
      ST_TICK: begin
        shift = 1'b1;
        hmode = HM_TICK;
      end
      ST_DRAW:  shift = !cell_q[0].live || out_free;
      default:  shift = 1'b0;
    endcase
  end

  ppe_head u_head (
    .mode         (hmode),
    .slot_in      (cell_q[0]),
    .player_x     (px_r),
    .player_y     (py_r),
    .invulnerable (invul_r),
    .load_x       (px_r),
    .load_y       (py_r),
    .load_vx      (load_vx),
    .load_vy      (load_vy),
    .slot_out     (head_out),
    .stat         (hstat)
  );

  for (genvar k = 0; k < POOL_SIZE; k++) begin : g_ring
    if (k == POOL_SIZE - 1) begin : g_tail
      ppe_cell u_cell (.clk(clk), .rst(rst), .clear(clear_all), .shift(shift),
                       .d(head_out), .q(cell_q[k]));
    end else begin : g_body
      ppe_cell u_cell (.clk(clk), .rst(rst), .clear(clear_all), .shift(shift),
                       .d(cell_q[k+1]), .q(cell_q[k]));
    end
    assign lives[k] = cell_q[k].live;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= operation;
      px_r    <= pos_x;
      py_r    <= pos_y;
      vx_r    <= vel_x;
      vy_r    <= vel_y;
      step_r  <= angle_step[4:0];
      invul_r <= invulnerable;
      first_r <= first_slot[5:0];
      slots   <= slots_next;
      drawn   <= drawn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head           <= '0;
      cursor         <= '0;
      phase          <= '0;
      live_count     <= '0;
      peak_live      <= '0;
      graze_total    <= '0;
      hit_flag       <= 1'b0;
      spawn_counter  <= '0;
      reject_counter <= '0;
      out_valid      <= 1'b0;
      fan_r          <= 1'b0;
      zero_cnt       <= 1'b0;
      rem            <= '0;
      acc            <= '0;
      walk           <= '0;
      n              <= '0;
      angle          <= '0;
      spd_r          <= '0;
      target         <= '0;
    end else begin
      if (shift) head <= head_inc;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            acc      <= '0;
            zero_cnt <= 1'b0;
            fan_r    <= 1'b0;
            n        <= '0;
            walk     <= '0;
            case (operation)
              OP_CLEAR, OP_RESET: begin
                live_count  <= '0;
                hit_flag    <= 1'b0;
                graze_total <= '0;
                if (operation == OP_RESET) begin
                  peak_live      <= '0;
                  spawn_counter  <= '0;
                  reject_counter <= '0;
                  cursor         <= '0;
                  phase          <= '0;
                end
                state <= ST_DONE;
              end
              OP_SPAWN: begin
                rem   <= CW'(1);
                state <= ST_POINT;
              end
              OP_FAN: begin
                fan_r <= 1'b1;
                rem   <= ({1'b0, count} > 9'(POOL_SIZE)) ? CW'(POOL_SIZE) : CW'(count);
                angle <= direction[4:0];
                spd_r <= (speed > 8'd64) ? 7'd64 : speed[6:0];
                state <= ST_POINT;
              end
              OP_TICK: begin
                live_count  <= '0;
                hit_flag    <= 1'b0;
                graze_total <= '0;
                state       <= ST_TICK;
              end
              OP_DRAW: begin
                if (first_slot >= 8'(SPRITES)) begin
                  zero_cnt <= 1'b1;
                  state    <= ST_DONE;
                end else begin
                  phase  <= ph_next;
                  target <= ph_next;
                  if (slots_next == '0) begin
                    zero_cnt <= 1'b1;
                    state    <= ST_DONE;
                  end else if (drawn_next == '0) begin
                    state <= ST_HIDE;
                  end else begin
                    state <= ST_SEEK;
                  end
                end
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_POINT: begin
          if (rem == '0) begin
            state <= ST_DONE;
          end else if (bad_pos || pool_full) begin
            reject_counter <= reject_counter + 16'd1;
            rem            <= rem - 1'b1;
            angle          <= angle + step_r;
          end else begin
            target <= cursor;
            state  <= ST_SEEK;
          end
        end
        ST_SEEK: begin
          if (head == target) state <= (op_r == OP_DRAW) ? ST_DRAW : ST_SPAWN;
        end
        ST_SPAWN: begin
          if (!cell_q[0].live) begin
            cursor        <= head_inc;
            live_count    <= live_count + 1'b1;
            if (live_count + 1'b1 > peak_live) peak_live <= live_count + 1'b1;
            spawn_counter <= spawn_counter + 16'd1;
            acc           <= acc + 1'b1;
            rem           <= rem - 1'b1;
            angle         <= angle + step_r;
            state         <= ST_POINT;
          end
        end
        ST_TICK: begin
          if (hstat.alive) live_count <= live_count + 1'b1;
          if (hstat.hit) hit_flag <= 1'b1;
          if (hstat.graze) graze_total <= graze_total + 1'b1;
          walk <= walk + 1'b1;
          if (walk == CW'(POOL_SIZE - 1)) state <= ST_DONE;
        end
        ST_DRAW: begin
          if (cell_q[0].live && out_free) begin
            sprite_action <= ACT_SHOW;
            sprite_index  <= 6'(first_r + n[5:0]);
            sprite_x      <= cell_q[0].px - 8'd4;
            sprite_y      <= cell_q[0].py - 8'd5;
            last          <= (n + 7'd1 == slots);
            accepted      <= '0;
            count_value   <= drawn;
            hit           <= hit_flag;
            graze_count   <= 7'(graze_total);
            peak_count    <= 7'(peak_live);
            spawned_total <= spawn_counter;
            rejected_total <= reject_counter;
            n <= n + 7'd1;
            if (n + 7'd1 == drawn) state <= (drawn == slots) ? ST_IDLE : ST_HIDE;
          end
        end
        ST_HIDE: begin
          if (out_free) begin
            sprite_action <= ACT_HIDE;
            sprite_index  <= 6'(first_r + n[5:0]);
            sprite_x      <= '0;
            sprite_y      <= '0;
            last          <= (n + 7'd1 == slots);
            accepted      <= '0;
            count_value   <= drawn;
            hit           <= hit_flag;
            graze_count   <= 7'(graze_total);
            peak_count    <= 7'(peak_live);
            spawned_total <= spawn_counter;
            rejected_total <= reject_counter;
            n <= n + 7'd1;
            if (n + 7'd1 == slots) state <= ST_IDLE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            sprite_action <= ACT_STATUS;
            sprite_index  <= '0;
            sprite_x      <= '0;
            sprite_y      <= '0;
            last          <= 1'b1;
            accepted      <= 7'(acc);
            count_value   <= zero_cnt ? 7'd0 : 7'(live_count);
            hit           <= hit_flag;
            graze_count   <= 7'(graze_total);
            peak_count    <= 7'(peak_live);
            spawned_total <= spawn_counter;
            rejected_total <= reject_counter;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= CW'(POOL_SIZE))
    else $error("live count above pool size");

  a_live_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(lives) == int'(live_count)))
    else $error("live count disagrees with live flags");

  a_search_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPAWN) |-> (live_count < CW'(POOL_SIZE)))
    else $error("slot search entered with a full pool");

endmodule

// File: verif/ppe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_checker
// Watches both channels of the point pool engine. It keeps its own copy of the
// pool, works out the status and sprite results of each accepted transaction
// and compares every returned result, in all its fields, with the oldest one due.
// ----------------------------------------------------------------------------
module ppe_checker
  import ppe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [7:0]  vel_x,
  input  logic [7:0]  vel_y,
  input  logic [7:0]  direction,
  input  logic [7:0]  angle_step,
  input  logic [7:0]  count,
  input  logic [7:0]  speed,
  input  logic        invulnerable,
  input  logic [7:0]  first_slot,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  sprite_action,
  input  logic [5:0]  sprite_index,
  input  logic [7:0]  sprite_x,
  input  logic [7:0]  sprite_y,
  input  logic        last,
  input  logic [6:0]  accepted,
  input  logic        hit,
  input  logic [6:0]  graze_count,
  input  logic [6:0]  count_value,
  input  logic [6:0]  peak_count,
  input  logic [15:0] spawned_total,
  input  logic [15:0] rejected_total,
  output int          errors,
  output int          pending
);

  localparam int SLOTS = 64;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  index;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic        lst;
    logic [6:0]  acc;
    logic        hit;
    logic [6:0]  grazes;
    logic [6:0]  live;
    logic [6:0]  peak;
    logic [15:0] spawned;
    logic [15:0] rejected;
  } pool_result_t;

  const int sine_mag_tab[16] = '{0, 12, 24, 36, 45, 53, 59, 63,
                                 64, 63, 59, 53, 45, 36, 24, 12};

  pool_result_t results_due[$];
  logic [15:0] pos_qx [SLOTS];
  logic [15:0] pos_qy [SLOTS];
  logic [15:0] step_qx [SLOTS];
  logic [15:0] step_qy [SLOTS];
  bit          alive [SLOTS];
  bit          grazed [SLOTS];
  logic [6:0]  live_n, peak_n, graze_n;
  bit          hit_f;
  logic [15:0] spawn_n, reject_n;
  int          cursor, phase;

  function automatic void post_result(logic [1:0] act, int idx, logic [7:0] sx,
                                      logic [7:0] sy, bit lst, int acc, int live);
    pool_result_t r;
    r.action = act;
    r.index = 6'(idx);
    r.sx = sx;
    r.sy = sy;
    r.lst = lst;
    r.acc = 7'(acc);
    r.hit = hit_f;
    r.grazes = graze_n;
    r.live = 7'(live);
    r.peak = peak_n;
    r.spawned = spawn_n;
    r.rejected = reject_n;
    results_due.push_back(r);
  endfunction

  function automatic void empty_pool();
    foreach (alive[i]) alive[i] = 0;
    live_n = 0;
    hit_f = 0;
    graze_n = 0;
  endfunction

  function automatic logic [7:0] fan_step(int ang, int spd);
    int m;
    m = sine_mag_tab[ang & 15] * spd / 64;
    return (ang & 16) ? 8'(-m) : 8'(m);
  endfunction

  function automatic int place_point(int x, int y, logic [7:0] vx, logic [7:0] vy);
    int i;
    if (x < X_MIN || x > X_MAX || y < Y_MIN || y > Y_MAX) begin
      reject_n++;
      return 0;
    end
    i = cursor;
    for (int n = 0; n < SLOTS; n++) begin
      if (!alive[i]) begin
        pos_qx[i] = {8'(x), 8'd0};
        pos_qy[i] = {8'(y), 8'd0};
        step_qx[i] = {{4{vx[7]}}, vx, 4'd0};
        step_qy[i] = {{4{vy[7]}}, vy, 4'd0};
        grazed[i] = 0;
        alive[i] = 1;
        cursor = (i + 1) % SLOTS;
        live_n++;
        if (live_n > peak_n) peak_n = live_n;
        spawn_n++;
        return 1;
      end
      i = (i + 1) % SLOTS;
    end
    reject_n++;
    return 0;
  endfunction

  function automatic void move_points(int plx, int ply, bit invul);
    int x, y, dx, dy;
    live_n = 0;
    hit_f = 0;
    graze_n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!alive[i]) continue;
      pos_qx[i] = pos_qx[i] + step_qx[i];
      x = pos_qx[i][15:8];
      if (x < X_MIN || x > X_MAX) begin
        alive[i] = 0;
        continue;
      end
      pos_qy[i] = pos_qy[i] + step_qy[i];
      y = pos_qy[i][15:8];
      if (y < Y_MIN || y > Y_MAX) begin
        alive[i] = 0;
        continue;
      end
      dx = (x > plx) ? x - plx : plx - x;
      dy = (y > ply) ? y - ply : ply - y;
      if (dx < HIT_R && dy < HIT_R) begin
        if (!invul) begin
          hit_f = 1;
          alive[i] = 0;
          continue;
        end
      end else if (!grazed[i] && dx < GRAZE_R && dy < GRAZE_R) begin
        grazed[i] = 1;
        graze_n++;
      end
      live_n++;
    end
  endfunction

  function automatic void draw_sprites(int first, int num);
    logic [7:0] xs [SLOTS];
    logic [7:0] ys [SLOTS];
    int slots, drawn, i;
    if (first >= SLOTS) begin
      post_result(ACT_STATUS, 0, 0, 0, 1, 0, 0);
      return;
    end
    slots = (num > SLOTS - first) ? SLOTS - first : num;
    phase = (phase + PHASE_STEP) % SLOTS;
    drawn = 0;
    i = phase;
    for (int n = 0; n < SLOTS; n++) begin
      if (alive[i] && drawn < slots) begin
        xs[drawn] = pos_qx[i][15:8] - 8'd4;
        ys[drawn] = pos_qy[i][15:8] - 8'd5;
        drawn++;
      end
      i = (i + 1) % SLOTS;
    end
    if (slots == 0) begin
      post_result(ACT_STATUS, 0, 0, 0, 1, 0, 0);
      return;
    end
    for (int n = 0; n < slots; n++) begin
      if (n < drawn) post_result(ACT_SHOW, first + n, xs[n], ys[n], n + 1 == slots, 0, drawn);
      else post_result(ACT_HIDE, first + n, 0, 0, n + 1 == slots, 0, drawn);
    end
  endfunction

  function automatic void predict();
    int acc, ang, spd, num;
    acc = 0;
    case (operation)
      OP_CLEAR: empty_pool();
      OP_RESET: begin
        empty_pool();
        peak_n = 0;
        spawn_n = 0;
        reject_n = 0;
        cursor = 0;
        phase = 0;
      end
      OP_SPAWN: acc = place_point(pos_x, pos_y, vel_x, vel_y);
      OP_FAN: begin
        ang = direction & 31;
        num = (count > SLOTS) ? SLOTS : count;
        spd = (speed > 64) ? 64 : speed;
        for (int k = 0; k < num; k++) begin
          acc += place_point(pos_x, pos_y, fan_step(ang + 8, spd), fan_step(ang, spd));
          ang = (ang + angle_step) & 31;
        end
      end
      OP_TICK: move_points(pos_x, pos_y, invulnerable);
      OP_DRAW: begin
        draw_sprites(first_slot, count);
        return;
      end
      default: ;
    endcase
    post_result(ACT_STATUS, 0, 0, 0, 1, acc, live_n);
  endfunction

  always @(posedge clk) begin
    pool_result_t got, want;
    if (rst) begin
      empty_pool();
      peak_n = 0;
      spawn_n = 0;
      reject_n = 0;
      cursor = 0;
      phase = 0;
      results_due.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {sprite_action, sprite_index, sprite_x, sprite_y, last, accepted, hit,
               graze_count, count_value, peak_count, spawned_total, rejected_total};
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, got);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
          end
        end
      end
      if (in_valid && !in_stall) predict();
    end
    pending = results_due.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

// File: verif/tb_projectile_pool_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_projectile_pool_engine_unit
// Drives the point pool engine with directed and random operations under
// random gaps and result stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_projectile_pool_engine_unit;
  import ppe_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  operation = 0;
  logic [7:0]  pos_x = 0, pos_y = 0, vel_x = 0, vel_y = 0;
  logic [7:0]  direction = 0, angle_step = 0, count = 0, speed = 0, first_slot = 0;
  logic        invulnerable = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  sprite_action;
  logic [5:0]  sprite_index;
  logic [7:0]  sprite_x, sprite_y;
  logic        last, hit;
  logic [6:0]  accepted, graze_count, count_value, peak_count;
  logic [15:0] spawned_total, rejected_total;
  int          errors, pending;
  bit          calm = 0;
  int          stall_left = 0;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  always #5 clk = ~clk;

  projectile_pool_engine_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .direction(direction), .angle_step(angle_step), .count(count), .speed(speed),
    .invulnerable(invulnerable), .first_slot(first_slot), .out_valid(out_valid),
    .out_stall(out_stall), .sprite_action(sprite_action), .sprite_index(sprite_index),
    .sprite_x(sprite_x), .sprite_y(sprite_y), .last(last), .accepted(accepted),
    .hit(hit), .graze_count(graze_count), .count_value(count_value),
    .peak_count(peak_count), .spawned_total(spawned_total),
    .rejected_total(rejected_total)
  );

  ppe_checker chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 0;
    end
  end

  task automatic issue(logic [2:0] op, logic [7:0] x, logic [7:0] y, logic [7:0] vx,
                       logic [7:0] vy, logic [7:0] dir, logic [7:0] stp, logic [7:0] num,
                       logic [7:0] spd, logic inv, logic [7:0] first);
    int g;
    operation <= op;
    pos_x <= x;
    pos_y <= y;
    vel_x <= vx;
    vel_y <= vy;
    direction <= dir;
    angle_step <= stp;
    count <= num;
    speed <= spd;
    invulnerable <= inv;
    first_slot <= first;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] near(int lo, int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  task automatic random_item();
    int r;
    bit arena;
    logic [7:0] x, y, vx, vy;
    r = $urandom_range(0, 99);
    arena = $urandom_range(0, 9) < 7;
    x = arena ? near(110, 145) : (($urandom_range(0, 3) == 0) ? near(0, 255) : near(8, 247));
    y = arena ? near(110, 145) : (($urandom_range(0, 3) == 0) ? near(0, 255) : near(24, 231));
    vx = arena ? 8'($signed($urandom_range(0, 32)) - 16) : 8'($urandom);
    vy = arena ? 8'($signed($urandom_range(0, 32)) - 16) : 8'($urandom);
    if (r < 30)
      issue(OP_SPAWN, x, y, vx, vy, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom);
    else if (r < 45)
      issue(OP_FAN, x, y, $urandom, $urandom, $urandom, $urandom,
            ($urandom_range(0, 9) == 0) ? near(0, 255) : near(0, 8),
            ($urandom_range(0, 2) == 0) ? near(0, 255) : near(0, 24), $urandom, $urandom);
    else if (r < 75)
      issue(OP_TICK, x, y, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom_range(0, 3) == 0, $urandom);
    else if (r < 90)
      issue(OP_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            ($urandom_range(0, 3) == 0) ? near(0, 255) : near(0, 12), $urandom, $urandom,
            ($urandom_range(0, 4) == 0) ? near(0, 255) : near(0, 63));
    else if (r < 93)
      issue(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom);
    else if (r < 96)
      issue(OP_RESET, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom);
    else
      issue(r[0] ? OP_SPARE_A : OP_SPARE_B, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    #100000000;
    $display("tb_projectile_pool_engine_unit NOT OK");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    issue(OP_SPAWN, 7, 100, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_SPAWN, 248, 100, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_SPAWN, 100, 23, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_SPAWN, 100, 232, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_SPAWN, 8, 24, 8'h80, 8'h7f, 0, 0, 0, 0, 0, 0);
    issue(OP_SPAWN, 247, 231, 8'h7f, 8'h80, 0, 0, 0, 0, 0, 0);
    issue(OP_SPAWN, 128, 128, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_TICK, 138, 128, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_TICK, 129, 129, 0, 0, 0, 0, 0, 0, 1, 0);
    issue(OP_TICK, 129, 129, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_FAN, 128, 128, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0);
    issue(OP_SPAWN, 100, 100, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_FAN, 100, 100, 0, 0, 3, 5, 4, 64, 0, 0);
    issue(OP_DRAW, 0, 0, 0, 0, 0, 0, 8'hff, 0, 0, 0);
    issue(OP_DRAW, 0, 0, 0, 0, 0, 0, 10, 0, 0, 60);
    issue(OP_DRAW, 0, 0, 0, 0, 0, 0, 5, 0, 0, 64);
    issue(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hff);
    issue(OP_TICK, 128, 128, 0, 0, 0, 0, 0, 0, 1, 0);
    issue(OP_SPARE_A, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_SPARE_B, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_DRAW, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0);
    issue(OP_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();
    for (int n = 0; n < 150; n++) begin
      if (n == 60) drain();
      calm <= (n >= 100 && n < 120);
      random_item();
    end
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_projectile_pool_engine_unit OK");
    else
      $display("tb_projectile_pool_engine_unit NOT OK");
    $finish;
  end

endmodule
